@@ src/ptw_pkg.sv @@
// Shared types and constants of the phase-to-waveform converter.
// No dependencies; imported by ptw_sine and phase_to_waveform.
package ptw_pkg;

   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_PULSE    = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_SAW      = 2'd3
   } wave_type;

   localparam int CSR_ADDR_BITS = 3;

   typedef enum logic {
      CSR_WAVE_SELECT = 1'b0,
      CSR_PULSE_WIDTH = 1'b1
   } csr_reg_type;

   localparam logic [31:0] PULSE_WIDTH_RESET = 32'h8000_0000;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;

   localparam logic [63:0] TAYLOR_DIV [8] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
   };

endpackage

@@ src/ptw_sine.sv @@
// Sine path of the phase-to-waveform converter: ROM lookup and linear interpolation.
// Depends on ptw_pkg; instantiated by phase_to_waveform.
module ptw_sine #(
   parameter int INDEX_BITS    = 10,
   parameter int FRACTION_BITS = 8,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [31:0]                   phase,
   output logic signed [SAMPLE_BITS-1:0] sine
);
   import ptw_pkg::*;

   localparam int ROM_DEPTH    = 1 << INDEX_BITS;
   localparam int QUARTER_BITS = INDEX_BITS - 2;
   localparam int QUARTER      = 1 << QUARTER_BITS;
   localparam logic [63:0] AMP_VALUE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
   localparam int PROD_BITS    = SAMPLE_BITS + FRACTION_BITS + 2;

   typedef logic signed [SAMPLE_BITS-1:0] rom_type [ROM_DEPTH];

   function automatic logic [63:0] quarter_sine(input int unsigned r);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      int                 n;
      x = ((64'(r) * HALF_PI_Q30) + 64'(QUARTER / 2)) >> QUARTER_BITS;
      x2 = ((x * x) + (Q30_ONE >> 1)) >> 30;
      term = x;
      sum = signed'(x);
      for (n = 0; n < 8; n++) begin
         term = (((term * x2) + (Q30_ONE >> 1)) >> 30) / TAYLOR_DIV[n];
         if (n[0] == 1'b0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      return ((unsigned'(sum) * AMP_VALUE) + (Q30_ONE >> 1)) >> 30;
   endfunction

   function automatic rom_type build_rom();
      rom_type     t;
      logic [63:0] v;
      int unsigned quad;
      int unsigned r;
      int          i;
      for (i = 0; i < ROM_DEPTH; i++) begin
         quad = unsigned'(i) >> QUARTER_BITS;
         r = unsigned'(i) & unsigned'(QUARTER - 1);
         if (quad[0]) begin
            v = quarter_sine(unsigned'(QUARTER) - r);
         end else begin
            v = quarter_sine(r);
         end
         if (quad[1]) begin
            t[i] = -signed'(SAMPLE_BITS'(v));
         end else begin
            t[i] = signed'(SAMPLE_BITS'(v));
         end
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [INDEX_BITS-1:0]           index;
   logic signed [SAMPLE_BITS-1:0]   left_ff;
   logic signed [SAMPLE_BITS-1:0]   right_ff;
   logic [FRACTION_BITS-1:0]        frac_ff;
   logic signed [SAMPLE_BITS:0]     step;
   logic signed [PROD_BITS-1:0]     prod_in;
   logic signed [PROD_BITS-1:0]     prod_ff;
   logic signed [SAMPLE_BITS-1:0]   base_ff;
   logic signed [PROD_BITS-1:0]     total;

   assign index = phase[31 -: INDEX_BITS];

   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= SINE_ROM[index];
         right_ff <= SINE_ROM[index + INDEX_BITS'(1)];
         frac_ff  <= phase[31-INDEX_BITS -: FRACTION_BITS];
      end
   end

   always_comb begin
      step    = (SAMPLE_BITS+1)'(right_ff) - (SAMPLE_BITS+1)'(left_ff);
      prod_in = PROD_BITS'(step) * signed'(PROD_BITS'({1'b0, frac_ff}));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         base_ff <= left_ff;
      end
   end

   assign total = (PROD_BITS'(base_ff) <<< FRACTION_BITS) + prod_ff
                  + (PROD_BITS'(1) <<< (FRACTION_BITS - 1));
   assign sine  = total[FRACTION_BITS +: SAMPLE_BITS];

endmodule

@@ src/phase_to_waveform.sv @@
// Top level of the phase-to-waveform converter: register port, pipeline and waveform select.
// Depends on ptw_pkg and ptw_sine.
//
// Each word on the req_ channel carries one 32-bit oscillator phase; each word on the
// rsp_ channel carries one signed sample in the waveform chosen by the wave_select
// register (sine, pulse, triangle or saw). The APB port at addresses 0 and 4 holds
// wave_select and pulse_width; change them only while no word is in flight.
// The pipeline has three register stages: ROM read and phase capture, the
// interpolation multiply and the pulse, triangle and saw paths, then the output
// register. rsp_valid rises once a word reaches the output register, and one phase is
// taken every cycle while the output does not stall. When the receiver stalls
// with a word waiting, all stages hold and req_ready drops until that word is taken;
// nothing is dropped or repeated.
// Reset empties the pipeline and sets wave_select to sine and pulse_width to half
// a cycle. The sine table is fixed logic and needs no fill after reset.
module phase_to_waveform #(
   parameter int INDEX_BITS    = 10,
   parameter int FRACTION_BITS = 8,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [31:0]                          req_phase,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ptw_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import ptw_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] AMP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   wave_type                      wave_select_ff;
   logic [31:0]                   pulse_width_ff;
   csr_reg_type                   csr_reg;

   logic                          advance;
   logic                          valid1_ff, valid2_ff, valid3_ff;
   logic [31:0]                   phase1_ff;
   wave_type                      sel1_ff, sel2_ff, sel3_ff;
   logic signed [SAMPLE_BITS-1:0] other_in, other2_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in, sample3_ff;
   logic signed [SAMPLE_BITS-1:0] sine;
   logic [29:0]                   tri_mag;
   logic [SAMPLE_BITS-2:0]        tri_top;
   logic signed [SAMPLE_BITS-1:0] saw_top;

   assign pready  = 1'b1;
   assign csr_reg = csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_select_ff <= WAVE_SINE;
         pulse_width_ff <= PULSE_WIDTH_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_reg)
            CSR_WAVE_SELECT: wave_select_ff <= wave_type'(pwdata[1:0]);
            CSR_PULSE_WIDTH: pulse_width_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         CSR_WAVE_SELECT: prdata = {30'd0, wave_select_ff};
         CSR_PULSE_WIDTH: prdata = pulse_width_ff;
         default:         prdata = 32'd0;
      endcase
   end

   assign advance   = !valid3_ff || rsp_ready;
   assign req_ready = advance;

   ptw_sine #(
      .INDEX_BITS    (INDEX_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_sine (
      .clock   (clock),
      .advance (advance),
      .phase   (req_phase),
      .sine    (sine)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= req_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_comb begin
      tri_mag = phase1_ff[30] ? ~phase1_ff[29:0] : phase1_ff[29:0];
      tri_top = tri_mag[29 -: (SAMPLE_BITS-1)];
      saw_top = signed'(phase1_ff[31 -: SAMPLE_BITS]);
      unique case (sel1_ff)
         WAVE_PULSE:    other_in = (phase1_ff < pulse_width_ff) ? AMP : -AMP;
         WAVE_TRIANGLE: other_in = phase1_ff[31] ? -signed'({1'b0, tri_top})
                                                 : signed'({1'b0, tri_top});
         WAVE_SAW:      other_in = (saw_top == MOST_NEGATIVE) ? AMP : -saw_top;
         default:       other_in = '0;
      endcase
   end

   assign sample_in = (sel2_ff == WAVE_SINE) ? sine : other2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         phase1_ff  <= req_phase;
         sel1_ff    <= wave_select_ff;
         sel2_ff    <= sel1_ff;
         other2_ff  <= other_in;
         sel3_ff    <= sel2_ff;
         sample3_ff <= sample_in;
      end
   end

   assign rsp_valid  = valid3_ff;
   assign rsp_sample = sample3_ff;

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Output word valid right after reset.");

   a_stage_reaches_output: assert property (@(posedge clock) disable iff (reset)
      valid2_ff && advance |=> rsp_valid)
      else $error("Word lost between the second stage and the output register.");

   a_pulse_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sel3_ff == WAVE_PULSE |-> rsp_sample == AMP || rsp_sample == -AMP)
      else $error("Pulse output is not at full scale.");

   a_saw_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sel3_ff == WAVE_SAW |-> rsp_sample != MOST_NEGATIVE)
      else $error("Saw output was not saturated.");

endmodule
